// ===== design/assert_macros.svh =====
// Assertion macros shared by the video unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TBVU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbvu assertion failed");

// next-cycle implication
`define TBVU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbvu assertion failed");

`endif

// ===== design/tbvu_pkg.sv =====
// Shared types, codes and address helpers of the background video unit
`default_nettype none

package tbvu_pkg;

    localparam int VRAM_DEPTH = 16384;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int OAM_DEPTH  = 256;
    localparam int OAM_AW     = $clog2(OAM_DEPTH);

    localparam logic [8:0] LINE_PRE  = 9'h1FF;
    localparam logic [8:0] LINE_VIS  = 9'd240;
    localparam logic [8:0] LINE_VBL  = 9'd241;
    localparam logic [8:0] LINE_LAST = 9'd260;
    localparam logic [8:0] DOT_LAST  = 9'd340;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_t;

    typedef enum logic [2:0] {
        FK_NONE   = 3'd0,
        FK_TILE   = 3'd1,
        FK_ATTR   = 3'd2,
        FK_PAT_LO = 3'd3,
        FK_PAT_HI = 3'd4
    } fetch_t;

    typedef enum logic [1:0] {
        SRC_DIRECT = 2'd0,
        SRC_VRAM   = 2'd1,
        SRC_OAM    = 2'd2
    } src_t;

    typedef struct packed {
        logic               rd_en;
        logic [VRAM_AW-1:0] rd_addr;
        logic               wr_en;
        logic [VRAM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } vram_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [OAM_AW-1:0] rd_addr;
        logic              wr_en;
        logic [OAM_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
    } oam_req_t;

    typedef struct packed {
        src_t       src;
        logic [7:0] rd_direct;
        logic       pixel_valid;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] pixel_color;
        logic       nmi_pulse;
        logic       frame_done;
        logic       access_error;
        fetch_t     fetch;
        logic [1:0] attr_sel;
    } stage_t;

    typedef struct packed {
        fetch_t     fetch;
        logic [1:0] attr_sel;
        logic [7:0] data;
    } fetch_ret_t;

    function automatic logic [VRAM_AW-1:0] map_nt(input logic [13:0] a);
        logic [13:0] r;
        r = a[13] ? {2'b10, a[11], 1'b0, a[9:0]} : a;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tbvu_chan_if.sv =====
// Valid/ready channel interfaces for items and results
`default_nettype none

interface tbvu_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] reg_index;
    logic [7:0] write_data;

    modport source (output valid, output command, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input command, input reg_index, input write_data,
                  output ready);
endinterface

interface tbvu_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_color;
    logic       nmi_pulse;
    logic       frame_done;
    logic       access_error;

    modport source (output valid, output read_data, output pixel_valid, output pixel_x,
                    output pixel_y, output pixel_color, output nmi_pulse,
                    output frame_done, output access_error, input ready);
    modport sink (input valid, input read_data, input pixel_valid, input pixel_x,
                  input pixel_y, input pixel_color, input nmi_pulse,
                  input frame_done, input access_error, output ready);
endinterface

`default_nettype wire

// ===== design/tbvu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data
`default_nettype none

module tbvu_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/tbvu_ctrl.sv =====
// Register file, dot sequencer, scroll logic, shifters and palette of the video unit
`default_nettype none

`include "assert_macros.svh"

module tbvu_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [1:0]           command,
    input  wire logic [2:0]           reg_index,
    input  wire logic [7:0]           write_data,
    input  wire tbvu_pkg::fetch_ret_t fret,
    output tbvu_pkg::vram_req_t       vreq,
    output tbvu_pkg::oam_req_t        oreq,
    output tbvu_pkg::stage_t          stage
);

    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic        vblank_reg, vblank_next;
    logic [14:0] vaddr_reg, vaddr_next;
    logic [14:0] taddr_reg, taddr_next;
    logic [2:0]  finex_reg, finex_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  oamidx_reg, oamidx_next;
    logic [8:0]  line_reg, line_next;
    logic [8:0]  dot_reg, dot_next;
    logic [15:0] bsl_reg, bsl_next;
    logic [15:0] bsh_reg, bsh_next;
    logic [15:0] asl_reg, asl_next;
    logic [15:0] ash_reg, ash_next;
    logic [7:0]  tile_reg;
    logic [1:0]  attr_reg;
    logic [7:0]  plo_reg;
    logic [7:0]  phi_reg;
    logic [7:0]  pal_reg [32];

    logic        pal_we;
    logic [4:0]  pal_waddr;
    logic [4:0]  pal_raddr;
    logic [7:0]  pal_rdata;
    logic [8:0]  dot_eff;
    logic [8:0]  dot_m1;
    logic [8:0]  dot_inc;
    logic        render_on;
    logic        bg_on;
    logic        rend_line;
    logic        pre_line;
    logic        window;
    logic [3:0]  tap;
    logic [14:0] v_w;
    logic [14:0] v_step;
    logic [13:0] pat_addr;
    logic [7:0]  attr_t;

    function automatic logic [14:0] inc_x(input logic [14:0] v);
        logic [14:0] r;
        r = v;
        if (v[4:0] == 5'd31)
        begin
            r[4:0] = 5'd0;
            r[10]  = ~v[10];
        end
        else
        begin
            r[4:0] = v[4:0] + 5'd1;
        end
        return r;
    endfunction

    function automatic logic [14:0] inc_y(input logic [14:0] v);
        logic [14:0] r;
        logic [4:0]  y;
        r = v;
        y = v[9:5];
        if (v[14:12] != 3'd7)
        begin
            r[14:12] = v[14:12] + 3'd1;
        end
        else
        begin
            r[14:12] = 3'd0;
            if (y == 5'd29)
            begin
                y     = 5'd0;
                r[11] = ~v[11];
            end
            else if (y == 5'd31)
            begin
                y = 5'd0;
            end
            else
            begin
                y = y + 5'd1;
            end
            r[9:5] = y;
        end
        return r;
    endfunction

    assign pal_rdata = pal_reg[pal_raddr];
    assign render_on = mask_reg[4] | mask_reg[3];
    assign bg_on     = mask_reg[3];
    assign dot_eff   = (line_reg == 9'd0 && dot_reg == 9'd0) ? 9'd1 : dot_reg;
    assign dot_m1    = dot_eff - 9'd1;
    assign dot_inc   = dot_eff + 9'd1;
    assign pre_line  = (line_reg == tbvu_pkg::LINE_PRE);
    assign rend_line = pre_line || (line_reg < tbvu_pkg::LINE_VIS);
    assign window    = (dot_eff >= 9'd2 && dot_eff <= 9'd257)
                    || (dot_eff >= 9'd321 && dot_eff <= 9'd337);
    assign tap       = 4'd15 - {1'b0, finex_reg};
    assign v_step    = vaddr_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
    assign pat_addr  = {1'b0, ctrl_reg[4], tile_reg, 1'b0, vaddr_reg[14:12]};

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        vblank_next = vblank_reg;
        vaddr_next  = vaddr_reg;
        taddr_next  = taddr_reg;
        finex_next  = finex_reg;
        toggle_next = toggle_reg;
        oamidx_next = oamidx_reg;
        line_next   = line_reg;
        dot_next    = dot_reg;
        bsl_next    = bsl_reg;
        bsh_next    = bsh_reg;
        asl_next    = asl_reg;
        ash_next    = ash_reg;
        vreq        = '0;
        oreq        = '0;
        stage       = '0;
        pal_we      = 1'b0;
        pal_waddr   = vaddr_reg[4:0];
        pal_raddr   = vaddr_reg[4:0];
        v_w         = vaddr_reg;
        if (accept)
        begin
            unique case (tbvu_pkg::cmd_t'(command))
                tbvu_pkg::CMD_TICK:
                begin
                    if (rend_line)
                    begin
                        if (pre_line && dot_eff == 9'd1)
                        begin
                            vblank_next = 1'b0;
                        end
                        if (window)
                        begin
                            if (dot_eff <= 9'd257 && !pre_line && bg_on)
                            begin
                                pal_raddr = {1'b0, ash_reg[tap], asl_reg[tap],
                                             bsh_reg[tap], bsl_reg[tap]};
                                stage.pixel_valid = 1'b1;
                                stage.pixel_x     = dot_m1[7:0];
                                stage.pixel_y     = line_reg[7:0];
                                stage.pixel_color = pal_rdata;
                            end
                            if (bg_on)
                            begin
                                bsl_next = {bsl_reg[14:0], 1'b0};
                                bsh_next = {bsh_reg[14:0], 1'b0};
                                asl_next = {asl_reg[14:0], 1'b0};
                                ash_next = {ash_reg[14:0], 1'b0};
                            end
                            unique case (dot_m1[2:0])
                                3'd0:
                                begin
                                    bsl_next = {bsl_next[15:8], plo_reg};
                                    bsh_next = {bsh_next[15:8], phi_reg};
                                    asl_next = {asl_next[15:8], {8{attr_reg[0]}}};
                                    ash_next = {ash_next[15:8], {8{attr_reg[1]}}};
                                    vreq.rd_en   = 1'b1;
                                    vreq.rd_addr = tbvu_pkg::map_nt({2'b10, vaddr_reg[11:0]});
                                    stage.fetch  = tbvu_pkg::FK_TILE;
                                end
                                3'd2:
                                begin
                                    vreq.rd_en    = 1'b1;
                                    vreq.rd_addr  = tbvu_pkg::map_nt({2'b10, vaddr_reg[11:10],
                                        4'b1111, vaddr_reg[9:7], vaddr_reg[4:2]});
                                    stage.fetch   = tbvu_pkg::FK_ATTR;
                                    stage.attr_sel = {vaddr_reg[6], vaddr_reg[1]};
                                end
                                3'd4:
                                begin
                                    vreq.rd_en   = 1'b1;
                                    vreq.rd_addr = pat_addr;
                                    stage.fetch  = tbvu_pkg::FK_PAT_LO;
                                end
                                3'd6:
                                begin
                                    vreq.rd_en   = 1'b1;
                                    vreq.rd_addr = pat_addr | 14'd8;
                                    stage.fetch  = tbvu_pkg::FK_PAT_HI;
                                end
                                3'd7:
                                begin
                                    if (render_on)
                                    begin
                                        v_w = inc_x(v_w);
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        if (render_on && dot_eff == 9'd256)
                        begin
                            v_w = inc_y(v_w);
                        end
                        if (render_on && dot_eff == 9'd257)
                        begin
                            v_w = (v_w & ~15'h041F) | (taddr_reg & 15'h041F);
                        end
                        if (render_on && pre_line && dot_eff >= 9'd280 && dot_eff <= 9'd304)
                        begin
                            v_w = (v_w & ~15'h7BE0) | (taddr_reg & 15'h7BE0);
                        end
                        vaddr_next = v_w;
                    end
                    if (line_reg == tbvu_pkg::LINE_VBL && dot_reg == 9'd1)
                    begin
                        vblank_next     = 1'b1;
                        stage.nmi_pulse = ctrl_reg[7];
                    end
                    if (dot_eff == tbvu_pkg::DOT_LAST)
                    begin
                        dot_next = 9'd0;
                        if (pre_line)
                        begin
                            line_next = 9'd0;
                        end
                        else if (line_reg == tbvu_pkg::LINE_LAST)
                        begin
                            line_next        = tbvu_pkg::LINE_PRE;
                            stage.frame_done = 1'b1;
                        end
                        else
                        begin
                            line_next = line_reg + 9'd1;
                        end
                    end
                    else
                    begin
                        dot_next = dot_inc;
                    end
                end
                tbvu_pkg::CMD_READ:
                begin
                    unique case (tbvu_pkg::reg_t'(reg_index))
                        tbvu_pkg::REG_STATUS:
                        begin
                            stage.rd_direct = {vblank_reg, 7'd0};
                            vblank_next     = 1'b0;
                            toggle_next     = 1'b0;
                        end
                        tbvu_pkg::REG_OAM_DATA:
                        begin
                            oreq.rd_en   = 1'b1;
                            oreq.rd_addr = oamidx_reg;
                            stage.src    = tbvu_pkg::SRC_OAM;
                        end
                        tbvu_pkg::REG_DATA:
                        begin
                            if (vaddr_reg[13:8] == 6'h3F)
                            begin
                                stage.rd_direct = pal_rdata;
                            end
                            else
                            begin
                                vreq.rd_en   = 1'b1;
                                vreq.rd_addr = tbvu_pkg::map_nt(vaddr_reg[13:0]);
                                stage.src    = tbvu_pkg::SRC_VRAM;
                            end
                            vaddr_next = v_step;
                        end
                        default:
                        begin
                            stage.access_error = 1'b1;
                        end
                    endcase
                end
                tbvu_pkg::CMD_WRITE:
                begin
                    unique case (tbvu_pkg::reg_t'(reg_index))
                        tbvu_pkg::REG_CTRL:
                        begin
                            ctrl_next         = write_data;
                            taddr_next[11:10] = write_data[1:0];
                        end
                        tbvu_pkg::REG_MASK:
                        begin
                            mask_next = write_data;
                        end
                        tbvu_pkg::REG_STATUS:
                        begin
                            stage.access_error = 1'b1;
                        end
                        tbvu_pkg::REG_OAM_ADDR:
                        begin
                            oamidx_next = write_data;
                        end
                        tbvu_pkg::REG_OAM_DATA:
                        begin
                            oreq.wr_en   = 1'b1;
                            oreq.wr_addr = oamidx_reg;
                            oreq.wr_data = write_data;
                            oamidx_next  = oamidx_reg + 8'd1;
                        end
                        tbvu_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                taddr_next[4:0] = write_data[7:3];
                                finex_next      = write_data[2:0];
                                toggle_next     = 1'b1;
                            end
                            else
                            begin
                                taddr_next[14:12] = write_data[2:0];
                                taddr_next[9:5]   = write_data[7:3];
                                toggle_next       = 1'b0;
                            end
                        end
                        tbvu_pkg::REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                taddr_next[14:8] = {1'b0, write_data[5:0]};
                                toggle_next      = 1'b1;
                            end
                            else
                            begin
                                taddr_next[7:0] = write_data;
                                vaddr_next      = {taddr_reg[14:8], write_data};
                                toggle_next     = 1'b0;
                            end
                        end
                        tbvu_pkg::REG_DATA:
                        begin
                            if (vaddr_reg[13:8] == 6'h3F)
                            begin
                                pal_we = 1'b1;
                            end
                            else
                            begin
                                vreq.wr_en   = 1'b1;
                                vreq.wr_addr = tbvu_pkg::map_nt(vaddr_reg[13:0]);
                                vreq.wr_data = write_data;
                            end
                            vaddr_next = v_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        attr_t = fret.data;
        if (fret.attr_sel[1])
        begin
            attr_t = {4'd0, attr_t[7:4]};
        end
        if (fret.attr_sel[0])
        begin
            attr_t = {2'd0, attr_t[7:2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            mask_reg   <= '0;
            vblank_reg <= 1'b0;
            vaddr_reg  <= '0;
            taddr_reg  <= '0;
            finex_reg  <= '0;
            toggle_reg <= 1'b0;
            oamidx_reg <= '0;
            line_reg   <= '0;
            dot_reg    <= '0;
            bsl_reg    <= '0;
            bsh_reg    <= '0;
            asl_reg    <= '0;
            ash_reg    <= '0;
            tile_reg   <= '0;
            attr_reg   <= '0;
            plo_reg    <= '0;
            phi_reg    <= '0;
            for (int i = 0; i < 32; i++)
            begin
                pal_reg[i] <= '0;
            end
        end
        else
        begin
            ctrl_reg   <= ctrl_next;
            mask_reg   <= mask_next;
            vblank_reg <= vblank_next;
            vaddr_reg  <= vaddr_next;
            taddr_reg  <= taddr_next;
            finex_reg  <= finex_next;
            toggle_reg <= toggle_next;
            oamidx_reg <= oamidx_next;
            line_reg   <= line_next;
            dot_reg    <= dot_next;
            bsl_reg    <= bsl_next;
            bsh_reg    <= bsh_next;
            asl_reg    <= asl_next;
            ash_reg    <= ash_next;
            if (pal_we)
            begin
                pal_reg[pal_waddr] <= write_data;
            end
            unique case (fret.fetch)
                tbvu_pkg::FK_TILE:   tile_reg <= fret.data;
                tbvu_pkg::FK_ATTR:   attr_reg <= attr_t[1:0];
                tbvu_pkg::FK_PAT_LO: plo_reg  <= fret.data;
                tbvu_pkg::FK_PAT_HI: phi_reg  <= fret.data;
                default:
                begin
                end
            endcase
        end
    end

    `TBVU_ASSERT_IMP(a_dot_range, clk, rst_n, 1'b1, dot_reg <= tbvu_pkg::DOT_LAST)
    `TBVU_ASSERT_IMP(a_line_range, clk, rst_n, 1'b1,
        line_reg <= tbvu_pkg::LINE_LAST || line_reg == tbvu_pkg::LINE_PRE)

endmodule

`default_nettype wire

// ===== design/tile_background_video_unit_core.sv =====
// Top level of the background video unit: front stage, memory stage and result register
// An item is registered in s1_reg; the memory stage then loads the result register.
// One item per cycle if results drain; fetches and reads share the one VRAM read port.
// Reset: asynchronous; then a pass over all VRAM addresses zeroes VRAM and OAM,
// during which no item is accepted.
`default_nettype none

`include "assert_macros.svh"

module tile_background_video_unit_core (
    input wire logic      clk,
    input wire logic      rst_n,
    tbvu_item_if.sink     item,
    tbvu_result_if.source result
);

    logic                          clr_busy_reg, clr_busy_next;
    logic [tbvu_pkg::VRAM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                          s1_valid_reg, s1_valid_next;
    tbvu_pkg::stage_t              s1_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    rd_data_reg;
    logic                          pix_valid_reg;
    logic [7:0]                    pix_x_reg;
    logic [7:0]                    pix_y_reg;
    logic [7:0]                    pix_color_reg;
    logic                          nmi_reg;
    logic                          frame_reg;
    logic                          err_reg;

    logic                 accept;
    logic                 s1_move;
    tbvu_pkg::vram_req_t  vreq;
    tbvu_pkg::oam_req_t   oreq;
    tbvu_pkg::stage_t     stage;
    tbvu_pkg::fetch_ret_t fret;
    logic [7:0]           vram_q;
    logic [7:0]           oam_q;
    logic [7:0]           s1_rdata;

    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !clr_busy_reg && (!s1_valid_reg || s1_move);
    assign accept     = item.valid && item.ready;

    assign fret.fetch    = s1_move ? s1_reg.fetch : tbvu_pkg::FK_NONE;
    assign fret.attr_sel = s1_reg.attr_sel;
    assign fret.data     = vram_q;

    tbvu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (item.command),
        .reg_index  (item.reg_index),
        .write_data (item.write_data),
        .fret       (fret),
        .vreq       (vreq),
        .oreq       (oreq),
        .stage      (stage)
    );

    tbvu_ram #(.DEPTH(tbvu_pkg::VRAM_DEPTH)) u_vram (
        .clk     (clk),
        .wr_en   (clr_busy_reg || vreq.wr_en),
        .wr_addr (clr_busy_reg ? clr_cnt_reg : vreq.wr_addr),
        .wr_data (clr_busy_reg ? 8'd0 : vreq.wr_data),
        .rd_en   (vreq.rd_en),
        .rd_addr (vreq.rd_addr),
        .rd_data (vram_q)
    );

    tbvu_ram #(.DEPTH(tbvu_pkg::OAM_DEPTH)) u_oam (
        .clk     (clk),
        .wr_en   (clr_busy_reg || oreq.wr_en),
        .wr_addr (clr_busy_reg ? clr_cnt_reg[tbvu_pkg::OAM_AW-1:0] : oreq.wr_addr),
        .wr_data (clr_busy_reg ? 8'd0 : oreq.wr_data),
        .rd_en   (oreq.rd_en),
        .rd_addr (oreq.rd_addr),
        .rd_data (oam_q)
    );

    always_comb
    begin
        unique case (s1_reg.src)
            tbvu_pkg::SRC_VRAM: s1_rdata = vram_q;
            tbvu_pkg::SRC_OAM:  s1_rdata = oam_q;
            default:            s1_rdata = s1_reg.rd_direct;
        endcase
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clr_busy_next = 1'b0;
            end
        end
        s1_valid_next  = accept || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage;
        end
        if (s1_move)
        begin
            rd_data_reg   <= s1_rdata;
            pix_valid_reg <= s1_reg.pixel_valid;
            pix_x_reg     <= s1_reg.pixel_x;
            pix_y_reg     <= s1_reg.pixel_y;
            pix_color_reg <= s1_reg.pixel_color;
            nmi_reg       <= s1_reg.nmi_pulse;
            frame_reg     <= s1_reg.frame_done;
            err_reg       <= s1_reg.access_error;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.read_data    = rd_data_reg;
    assign result.pixel_valid  = pix_valid_reg;
    assign result.pixel_x      = pix_x_reg;
    assign result.pixel_y      = pix_y_reg;
    assign result.pixel_color  = pix_color_reg;
    assign result.nmi_pulse    = nmi_reg;
    assign result.frame_done   = frame_reg;
    assign result.access_error = err_reg;

    `TBVU_ASSERT_IMP(a_clear_blocks, clk, rst_n, clr_busy_reg, !item.ready)
    `TBVU_ASSERT_NXT(a_accept_fills, clk, rst_n, accept, s1_valid_reg)
    `TBVU_ASSERT_NXT(a_stage_holds, clk, rst_n, s1_valid_reg && !s1_move,
        s1_valid_reg && $stable(s1_reg))

endmodule

`default_nettype wire
